// File: hw/rtl/c2s_pkg.sv
// Shared types, turn constants and the CORDIC stage angle table of the
// Cartesian to spherical converter. No dependencies.
package c2s_pkg;

	// Internal word: coordinates, magnitudes and angle accumulators
	localparam int WORD_W = 64;

	typedef logic [WORD_W-1:0] word_t;

	// Vector handed from one CORDIC cell to the next
	typedef struct packed {
		logic  valid;
		word_t x;
		word_t y;
		word_t acc;
	} vec_t;

	// Angles: 2^64 is one full turn
	localparam word_t HALF_TURN    = 64'h8000_0000_0000_0000;
	localparam word_t QUARTER_TURN = 64'h4000_0000_0000_0000;
	localparam word_t EIGHTH_TURN  = 64'h2000_0000_0000_0000;

	// 1/(2*pi) and the inverse CORDIC gain, both Q64
	localparam word_t INV_TWO_PI = 64'h28BE_60DB_9391_054A;
	localparam word_t INV_GAIN   = 64'h9B74_EDA8_435E_5A67;

	// Upper half of the full 128-bit product
	function automatic word_t mul_hi(word_t a, word_t b);
		logic [2*WORD_W-1:0] prod;
		prod = {{WORD_W{1'b0}}, a} * {{WORD_W{1'b0}}, b};
		return prod[2*WORD_W-1:WORD_W];
	endfunction

	// Restoring long division, used only while building the angle table
	function automatic word_t long_div(word_t num, word_t den);
		word_t         quo;
		logic [WORD_W:0] rem;
		quo = '0;
		rem = '0;
		for (int b = WORD_W - 1; b >= 0; b--) begin
			rem = {rem[WORD_W-1:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// atan(2^-idx) as a binary angle: truncated power series in radians,
	// then scaled by 1/(2*pi)
	function automatic word_t stage_angle(int idx);
		word_t p;
		word_t sum;
		word_t term;
		word_t den;
		if (idx == 0) begin
			return EIGHTH_TURN;
		end
		p   = word_t'(1) << (WORD_W - idx);
		sum = '0;
		for (int k = 0; k < WORD_W; k++) begin
			if (p != '0) begin
				den  = word_t'(2 * k + 1);
				term = long_div(p, den);
				if ((k & 1) != 0) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
				p = (2 * idx < WORD_W) ? (p >> (2 * idx)) : '0;
			end
		end
		return mul_hi(sum, INV_TWO_PI);
	endfunction

endpackage

// File: hw/rtl/c2s_cordic_cell.sv
// One CORDIC vectoring micro-rotation with its pipeline register.
// Depends on c2s_pkg; side data rides along unchanged.
module c2s_cordic_cell #(
	parameter int            STAGE       = 0,
	parameter int            SIDE_WIDTH  = 1,
	parameter c2s_pkg::word_t STAGE_ANGLE = '0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  c2s_pkg::vec_t         vec_in,
	input  logic [SIDE_WIDTH-1:0] side_in,
	output c2s_pkg::vec_t         vec_out,
	output logic [SIDE_WIDTH-1:0] side_out
);
	import c2s_pkg::*;

	word_t xs, ys;
	word_t x_nx, y_nx, acc_nx;
	logic  valid_q;
	word_t x_q, y_q, acc_q;
	logic [SIDE_WIDTH-1:0] side_q;

	// Rotate toward the x axis: clockwise while y is non-negative
	always_comb begin
		xs = word_t'($signed(vec_in.x) >>> STAGE);
		ys = word_t'($signed(vec_in.y) >>> STAGE);
		if (!vec_in.y[WORD_W-1]) begin
			x_nx   = vec_in.x + ys;
			y_nx   = vec_in.y - xs;
			acc_nx = vec_in.acc + STAGE_ANGLE;
		end else begin
			x_nx   = vec_in.x - ys;
			y_nx   = vec_in.y + xs;
			acc_nx = vec_in.acc - STAGE_ANGLE;
		end
	end

	// Advance the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= vec_in.valid;
		end
	end

	// Advance the payload
	always_ff @(posedge clk) begin
		if (en) begin
			x_q    <= x_nx;
			y_q    <= y_nx;
			acc_q  <= acc_nx;
			side_q <= side_in;
		end
	end

	assign vec_out  = '{valid: valid_q, x: x_q, y: y_q, acc: acc_q};
	assign side_out = side_q;

endmodule

// File: hw/rtl/c2s_gain_mul.sv
// Two-stage CORDIC gain compensation: magnitude times the Q64 inverse gain,
// upper 64 bits kept. Depends on c2s_pkg.
module c2s_gain_mul #(
	parameter int SIDE_WIDTH = 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  c2s_pkg::word_t        mag_in,
	input  logic [SIDE_WIDTH-1:0] side_in,
	output logic                  out_valid,
	output c2s_pkg::word_t        mag_out,
	output logic [SIDE_WIDTH-1:0] side_out
);
	import c2s_pkg::*;

	localparam int HW = WORD_W / 2;
	localparam logic [HW-1:0] GAIN_LO = INV_GAIN[HW-1:0];
	localparam logic [HW-1:0] GAIN_HI = INV_GAIN[WORD_W-1:HW];

	logic [HW-1:0]     mag_lo, mag_hi;
	word_t             ll_c, lh_c, hl_c, hh_c;
	word_t             ll_s1, lh_s1, hl_s1, hh_s1;
	logic              valid_s1, valid_s2;
	logic [SIDE_WIDTH-1:0] side_s1, side_s2;
	logic [2*WORD_W-1:0]   sum_c;
	word_t             mag_s2;

	// Four 32x32 partial products
	always_comb begin
		mag_lo = mag_in[HW-1:0];
		mag_hi = mag_in[WORD_W-1:HW];
		ll_c   = {{HW{1'b0}}, mag_lo} * {{HW{1'b0}}, GAIN_LO};
		lh_c   = {{HW{1'b0}}, mag_lo} * {{HW{1'b0}}, GAIN_HI};
		hl_c   = {{HW{1'b0}}, mag_hi} * {{HW{1'b0}}, GAIN_LO};
		hh_c   = {{HW{1'b0}}, mag_hi} * {{HW{1'b0}}, GAIN_HI};
	end

	// Align and add the partial products
	always_comb begin
		sum_c = {hh_s1, {WORD_W{1'b0}}}
		      + {{HW{1'b0}}, lh_s1, {HW{1'b0}}}
		      + {{HW{1'b0}}, hl_s1, {HW{1'b0}}}
		      + {{WORD_W{1'b0}}, ll_s1};
	end

	// Advance the valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// Advance the payload
	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1   <= ll_c;
			lh_s1   <= lh_c;
			hl_s1   <= hl_c;
			hh_s1   <= hh_c;
			side_s1 <= side_in;
			mag_s2  <= sum_c[2*WORD_W-1:WORD_W];
			side_s2 <= side_s1;
		end
	end

	assign out_valid = valid_s2;
	assign mag_out   = mag_s2;
	assign side_out  = side_s2;

endmodule

// File: hw/rtl/c2s_out_buf.sv
// Two-entry result buffer that parts the pipeline from the output channel.
// No dependencies.
module c2s_out_buf #(
	parameter int DATA_WIDTH = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic [DATA_WIDTH-1:0] push_data,
	output logic                  full,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [DATA_WIDTH-1:0] out_data
);
	logic [DATA_WIDTH-1:0] mem_q [2];
	logic                  wr_q, rd_q;
	logic [1:0]            cnt_q;
	logic                  pop;

	assign pop = out_valid & out_ready;

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Store an incoming result
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	assign full      = cnt_q[1];
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = mem_q[rd_q];

endmodule

// File: hw/rtl/cartesian_to_spherical_unit.sv
// Top level of the Cartesian to spherical converter: two CORDIC cell chains,
// gain multipliers and the result buffer. Depends on c2s_pkg and all c2s_ modules.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  cfg      | cfg_valid/cfg_ready  | three_dimensional (1 = 3-D, 0 = 2-D)
//  in       | in_valid/in_ready    | x_coord, y_coord, z_coord (signed)
//  out      | out_valid/out_ready  | radius, azimuth, polar_angle
//
// One point enters per cycle while in_ready is high; out_valid follows acceptance
// through the azimuth entry register, CORDIC_STAGES cells and two gain stages per
// pass, the polar entry register and the result buffer write.
// Reset clears all valid flags and the buffer, and selects 3-D mode.
// cfg_ready is always high. When both buffer entries hold unread results,
// in_ready drops and the whole pipeline holds until a result is taken.
module cartesian_to_spherical_unit #(
	parameter int COORD_WIDTH   = 32,
	parameter int ANGLE_WIDTH   = 32,
	parameter int CORDIC_STAGES = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          three_dimensional,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] x_coord,
	input  logic signed [COORD_WIDTH-1:0] y_coord,
	input  logic signed [COORD_WIDTH-1:0] z_coord,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [COORD_WIDTH-1:0]        radius,
	output logic [ANGLE_WIDTH-1:0]        azimuth,
	output logic [ANGLE_WIDTH-1:0]        polar_angle
);
	import c2s_pkg::*;

	localparam int GUARD = 61 - COORD_WIDTH;
	localparam int EXT_W = WORD_W - COORD_WIDTH;
	localparam int S1_W  = WORD_W + 1;
	localparam int G1_W  = WORD_W + ANGLE_WIDTH + 1;
	localparam int S2_W  = WORD_W + ANGLE_WIDTH + 2;
	localparam int G2_W  = S2_W + WORD_W;
	localparam int RES_W = COORD_WIDTH + 2 * ANGLE_WIDTH;
	localparam word_t ANG_HALF_LSB = word_t'(1) << (WORD_W - 1 - ANGLE_WIDTH);
	localparam word_t RAD_HALF_LSB = word_t'(1) << (GUARD - 1);

	logic mode_q;
	logic en;
	logic buf_full;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b1;
		end else if (cfg_valid) begin
			mode_q <= three_dimensional;
		end
	end

	assign cfg_ready = 1'b1;
	assign en        = ~buf_full;
	assign in_ready  = en;

	// ---------------- azimuth pass entry (s1) ----------------
	word_t xf, yf, zf;
	word_t x_c1, y_c1, acc_c1;
	logic  xy_zero_c1;
	logic  valid_s1;
	word_t x_s1, y_s1, acc_s1, z_s1;
	logic  xy_zero_s1;

	// Scale into the guard format and fold negative x into the right half-plane
	always_comb begin
		xf = {{EXT_W{x_coord[COORD_WIDTH-1]}}, x_coord} << GUARD;
		yf = {{EXT_W{y_coord[COORD_WIDTH-1]}}, y_coord} << GUARD;
		zf = {{EXT_W{z_coord[COORD_WIDTH-1]}}, z_coord} << GUARD;
		xy_zero_c1 = (x_coord == '0) && (y_coord == '0);
		if (xf[WORD_W-1]) begin
			x_c1   = '0 - xf;
			y_c1   = '0 - yf;
			acc_c1 = HALF_TURN;
		end else begin
			x_c1   = xf;
			y_c1   = yf;
			acc_c1 = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid & in_ready;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1       <= x_c1;
			y_s1       <= y_c1;
			acc_s1     <= acc_c1;
			z_s1       <= zf;
			xy_zero_s1 <= xy_zero_c1;
		end
	end

	// ---------------- azimuth chain ----------------
	vec_t            chain1 [CORDIC_STAGES+1];
	logic [S1_W-1:0] side1  [CORDIC_STAGES+1];

	assign chain1[0] = '{valid: valid_s1, x: x_s1, y: y_s1, acc: acc_s1};
	assign side1[0]  = {xy_zero_s1, z_s1};

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_az_cell
		c2s_cordic_cell #(
			.STAGE       (i),
			.SIDE_WIDTH  (S1_W),
			.STAGE_ANGLE (stage_angle(i))
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.vec_in   (chain1[i]),
			.side_in  (side1[i]),
			.vec_out  (chain1[i+1]),
			.side_out (side1[i+1])
		);
	end

	// Round the azimuth; zero it at the origin of the plane
	vec_t                   az_end;
	logic                   az_xy_zero;
	word_t                  az_z;
	word_t                  az_sum;
	logic [ANGLE_WIDTH-1:0] az_round;

	always_comb begin
		az_end     = chain1[CORDIC_STAGES];
		az_xy_zero = side1[CORDIC_STAGES][WORD_W];
		az_z       = side1[CORDIC_STAGES][WORD_W-1:0];
		az_sum     = az_end.acc + ANG_HALF_LSB;
		az_round   = az_xy_zero ? '0 : az_sum[WORD_W-1 -: ANGLE_WIDTH];
	end

	logic            g1_valid;
	word_t           rho_g1;
	logic [G1_W-1:0] g1_side;

	c2s_gain_mul #(
		.SIDE_WIDTH (G1_W)
	) u_gain_az (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (az_end.valid),
		.mag_in    (az_end.x),
		.side_in   ({az_xy_zero, az_round, az_z}),
		.out_valid (g1_valid),
		.mag_out   (rho_g1),
		.side_out  (g1_side)
	);

	// ---------------- polar pass entry (s2) ----------------
	word_t                  g1_z;
	logic [ANGLE_WIDTH-1:0] g1_az;
	logic                   g1_xy_zero;
	word_t                  x_c2, y_c2, acc_c2;
	logic                   zr_zero_c2;
	logic                   valid_s2;
	word_t                  x_s2, y_s2, acc_s2, rho_s2;
	logic [ANGLE_WIDTH-1:0] az_s2;
	logic                   xy_zero_s2, zr_zero_s2;

	// Vector (z, rho); fold negative z the same way
	always_comb begin
		g1_z       = g1_side[WORD_W-1:0];
		g1_az      = g1_side[WORD_W +: ANGLE_WIDTH];
		g1_xy_zero = g1_side[G1_W-1];
		zr_zero_c2 = (g1_z == '0) && (rho_g1 == '0);
		if (g1_z[WORD_W-1]) begin
			x_c2   = '0 - g1_z;
			y_c2   = '0 - rho_g1;
			acc_c2 = HALF_TURN;
		end else begin
			x_c2   = g1_z;
			y_c2   = rho_g1;
			acc_c2 = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= g1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2       <= x_c2;
			y_s2       <= y_c2;
			acc_s2     <= acc_c2;
			rho_s2     <= rho_g1;
			az_s2      <= g1_az;
			xy_zero_s2 <= g1_xy_zero;
			zr_zero_s2 <= zr_zero_c2;
		end
	end

	// ---------------- polar chain ----------------
	vec_t            chain2 [CORDIC_STAGES+1];
	logic [S2_W-1:0] side2  [CORDIC_STAGES+1];

	assign chain2[0] = '{valid: valid_s2, x: x_s2, y: y_s2, acc: acc_s2};
	assign side2[0]  = {xy_zero_s2, zr_zero_s2, az_s2, rho_s2};

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_pol_cell
		c2s_cordic_cell #(
			.STAGE       (i),
			.SIDE_WIDTH  (S2_W),
			.STAGE_ANGLE (stage_angle(i))
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.vec_in   (chain2[i]),
			.side_in  (side2[i]),
			.vec_out  (chain2[i+1]),
			.side_out (side2[i+1])
		);
	end

	vec_t            pol_end;
	logic            g2_valid;
	word_t           mag_g2;
	logic [G2_W-1:0] g2_side;

	assign pol_end = chain2[CORDIC_STAGES];

	c2s_gain_mul #(
		.SIDE_WIDTH (G2_W)
	) u_gain_pol (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (pol_end.valid),
		.mag_in    (pol_end.x),
		.side_in   ({pol_end.acc, side2[CORDIC_STAGES]}),
		.out_valid (g2_valid),
		.mag_out   (mag_g2),
		.side_out  (g2_side)
	);

	// ---------------- result formatting ----------------
	word_t                  fin_rho, fin_acc, pol_acc, pol_sum;
	word_t                  rad_src, rad_sum, rad_shift;
	logic [ANGLE_WIDTH-1:0] fin_az, fin_pol;
	logic [COORD_WIDTH-1:0] fin_rad;
	logic                   fin_zr_zero;

	always_comb begin
		fin_rho     = g2_side[WORD_W-1:0];
		fin_az      = g2_side[WORD_W +: ANGLE_WIDTH];
		fin_zr_zero = g2_side[S2_W-2];
		fin_acc     = g2_side[G2_W-1 -: WORD_W];

		// Clamp overshoot past pi: just above gives pi, wrapped below zero gives 0
		pol_acc = fin_acc;
		if (fin_acc > HALF_TURN) begin
			pol_acc = (fin_acc < HALF_TURN + QUARTER_TURN) ? HALF_TURN : '0;
		end
		pol_sum = pol_acc + ANG_HALF_LSB;
		fin_pol = (!mode_q || fin_zr_zero) ? '0 : pol_sum[WORD_W-1 -: ANGLE_WIDTH];

		// Round the radius out of the guard format and saturate
		if (mode_q) begin
			rad_src = fin_zr_zero ? '0 : mag_g2;
		end else begin
			rad_src = fin_rho;
		end
		rad_sum   = rad_src + RAD_HALF_LSB;
		rad_shift = rad_sum >> GUARD;
		if (|rad_shift[WORD_W-1:COORD_WIDTH]) begin
			fin_rad = '1;
		end else begin
			fin_rad = rad_shift[COORD_WIDTH-1:0];
		end
	end

	logic [RES_W-1:0] res_data;

	c2s_out_buf #(
		.DATA_WIDTH (RES_W)
	) u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (en & g2_valid),
		.push_data ({fin_rad, fin_az, fin_pol}),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (res_data)
	);

	assign radius      = res_data[RES_W-1 -: COORD_WIDTH];
	assign azimuth     = res_data[ANGLE_WIDTH +: ANGLE_WIDTH];
	assign polar_angle = res_data[ANGLE_WIDTH-1:0];

endmodule

// File: bench/cartesian_to_spherical_unit_test.sv
// Testbench for cartesian_to_spherical_unit: random and directed points in 2-D and 3-D
// mode, checked against a bit-exact fixed-point CORDIC predictor kept in this file.
// Depends only on the RTL of cartesian_to_spherical_unit.
`timescale 1ns / 100ps

module cartesian_to_spherical_unit_test;

	localparam int COORD_W    = 32;
	localparam int ANGLE_W    = 32;
	localparam int STAGES     = 32;
	localparam int GUARD_BITS = 61 - COORD_W;
	localparam int LATENCY    = 2 * STAGES + 7;
	localparam int IDLE_LIMIT = 3000;
	localparam int LONG_HOLD  = 400;
	localparam int PHASES     = 6;
	localparam int PHASE_LEN  = 215;

	typedef logic [63:0] u64;

	localparam u64 HALF_TURN    = 64'h8000_0000_0000_0000;
	localparam u64 QUARTER_TURN = 64'h4000_0000_0000_0000;
	localparam u64 EIGHTH_TURN  = 64'h2000_0000_0000_0000;
	localparam u64 INV_TWO_PI   = 64'h28BE_60DB_9391_054A;
	localparam u64 INV_GAIN     = 64'h9B74_EDA8_435E_5A67;

	localparam logic [COORD_W-1:0] C_MAX = 32'h7FFF_FFFF;
	localparam logic [COORD_W-1:0] C_MIN = 32'h8000_0000;
	localparam logic [COORD_W-1:0] C_M1  = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {JOB_POINT, JOB_MODE, JOB_DRAIN} job_kind_t;

	typedef struct {
		job_kind_t          kind;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		logic               mode;
	} job_t;

	typedef struct packed {
		u64 mag;
		u64 ang;
	} pass_t;

	typedef struct {
		logic [COORD_W-1:0] radius;
		logic [ANGLE_W-1:0] azimuth;
		logic [ANGLE_W-1:0] polar;
	} sph_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic three_dimensional = 1'b1;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [COORD_W-1:0] x_coord = '0;
	logic [COORD_W-1:0] y_coord = '0;
	logic [COORD_W-1:0] z_coord = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [COORD_W-1:0] radius;
	logic [ANGLE_W-1:0] azimuth;
	logic [ANGLE_W-1:0] polar_angle;

	u64   atan_turn [STAGES];
	job_t conversion_jobs[$];
	sph_t awaited_spherical[$];
	sph_t want;
	logic dims_3d = 1'b1;
	logic start_point;
	logic start_mode;
	logic settled;
	int   send_gap = 0;
	int   send_burst = 0;
	int   recv_stall = 0;
	int   recv_burst = 0;
	int   stall_len;
	int   results_checked = 0;
	int   mismatch_count = 0;
	int   idle_cycles = 0;
	bit   long_hold_done = 1'b0;

	cartesian_to_spherical_unit #(
		.COORD_WIDTH(COORD_W),
		.ANGLE_WIDTH(ANGLE_W),
		.CORDIC_STAGES(STAGES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.three_dimensional(three_dimensional),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.x_coord(x_coord),
		.y_coord(y_coord),
		.z_coord(z_coord),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.radius(radius),
		.azimuth(azimuth),
		.polar_angle(polar_angle)
	);

	// Upper 64 bits of an unsigned 64x64 product
	function automatic u64 hi_product(u64 a, u64 b);
		logic [127:0] prod;
		prod = {64'd0, a} * {64'd0, b};
		return prod[127:64];
	endfunction

	function automatic u64 asr(u64 v, int s);
		return $signed(v) >>> s;
	endfunction

	// atan(2^-i) in turns: truncated power series in Q64 radians, then / (2*pi)
	function automatic u64 atan_binary(int i);
		u64 p;
		u64 sum;
		u64 term;
		u64 k;
		if (i == 0) begin
			return EIGHTH_TURN;
		end
		p = 64'd1 << (64 - i);
		sum = '0;
		k = '0;
		while (p != '0) begin
			term = p / (2 * k + 1);
			if (k[0]) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
			p = (2 * i < 64) ? (p >> (2 * i)) : '0;
			k = k + 1;
		end
		return hi_product(sum, INV_TWO_PI);
	endfunction

	// One CORDIC vectoring pass: gain-corrected magnitude and angle of (x, y)
	function automatic pass_t cordic_vector(u64 x, u64 y);
		pass_t r;
		u64    acc;
		u64    xs;
		u64    ys;
		acc = '0;
		if (x[63]) begin
			x = -x;
			y = -y;
			acc = HALF_TURN;
		end
		for (int i = 0; i < STAGES; i++) begin
			xs = asr(x, i);
			ys = asr(y, i);
			if (!y[63]) begin
				x = x + ys;
				y = y - xs;
				acc = acc + atan_turn[i];
			end else begin
				x = x - ys;
				y = y + xs;
				acc = acc - atan_turn[i];
			end
		end
		r.mag = hi_product(x, INV_GAIN);
		r.ang = acc;
		return r;
	endfunction

	function automatic u64 scaled(logic [COORD_W-1:0] c);
		return {{(64 - COORD_W){c[COORD_W-1]}}, c} << GUARD_BITS;
	endfunction

	function automatic logic [ANGLE_W-1:0] angle_round(u64 acc);
		u64 t;
		t = acc + (64'd1 << (63 - ANGLE_W));
		return t[63:64-ANGLE_W];
	endfunction

	// Radius, azimuth and polar angle of one point under the given mode
	function automatic sph_t spherical_of(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
			logic [COORD_W-1:0] cz, logic mode_3d);
		u64    x;
		u64    y;
		u64    z;
		u64    rho;
		u64    az;
		u64    rad;
		u64    a;
		pass_t v;
		sph_t  r;
		x = scaled(cx);
		y = scaled(cy);
		z = scaled(cz);
		az = '0;
		r.polar = '0;
		if (x == '0 && y == '0) begin
			rho = '0;
		end else begin
			v = cordic_vector(x, y);
			rho = v.mag;
			az = v.ang;
		end
		rad = rho;
		if (mode_3d) begin
			if (z == '0 && rho == '0) begin
				rad = '0;
			end else begin
				v = cordic_vector(z, rho);
				rad = v.mag;
				a = v.ang;
				// clamp overshoot past pi, and wrap below zero, onto the valid range
				if (a > HALF_TURN) begin
					a = (a < HALF_TURN + QUARTER_TURN) ? HALF_TURN : '0;
				end
				r.polar = angle_round(a);
			end
		end
		rad = (rad + (64'd1 << (GUARD_BITS - 1))) >> GUARD_BITS;
		if (rad > 64'hFFFF_FFFF) begin
			rad = 64'hFFFF_FFFF;
		end
		r.radius = rad[COORD_W-1:0];
		r.azimuth = (x == '0 && y == '0) ? '0 : angle_round(az);
		return r;
	endfunction

	function automatic int idle_length();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) begin
			return 0;
		end
		if (roll < 95) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(15, 60);
	endfunction

	// Coordinate mix: full range, near zero, extremes, powers of two, shifted
	function automatic logic [COORD_W-1:0] pick_coord();
		logic [COORD_W-1:0] v;
		case ($urandom_range(0, 9))
			4, 5: v = $urandom_range(0, 16) - 8;
			6: begin
				case ($urandom_range(0, 4))
					0: v = '0;
					1: v = 32'd1;
					2: v = C_M1;
					3: v = C_MAX;
					default: v = C_MIN;
				endcase
			end
			7: begin
				v = 32'd1 << $urandom_range(0, 31);
				if ($urandom_range(0, 1)) v = -v;
			end
			8: v = '0;
			9: begin
				v = $urandom >> $urandom_range(0, 31);
				if ($urandom_range(0, 1)) v = -v;
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	function automatic void add_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
			logic [COORD_W-1:0] z);
		job_t j;
		j.kind = JOB_POINT;
		j.x = x;
		j.y = y;
		j.z = z;
		j.mode = 1'b0;
		conversion_jobs.push_back(j);
	endfunction

	function automatic void add_control(job_kind_t kind, logic mode);
		job_t j;
		j.kind = kind;
		j.x = '0;
		j.y = '0;
		j.z = '0;
		j.mode = mode;
		conversion_jobs.push_back(j);
	endfunction

	initial begin
		forever #10 clk = ~clk;
	end

	// Sender: predict each accepted point, then offer the next job
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			cfg_valid <= 1'b0;
			three_dimensional <= 1'b1;
			x_coord <= '0;
			y_coord <= '0;
			z_coord <= '0;
			dims_3d = 1'b1;
			send_gap = 0;
			send_burst = 0;
		end else begin
			if (in_valid && in_ready) begin
				awaited_spherical.push_back(spherical_of(x_coord, y_coord, z_coord, dims_3d));
			end
			if (cfg_valid && cfg_ready) begin
				dims_3d = three_dimensional;
			end
			settled = awaited_spherical.size() == 0 && !out_valid;
			// hold the payload until the transaction completes
			if (!(in_valid && !in_ready) && !(cfg_valid && !cfg_ready)) begin
				start_point = 1'b0;
				start_mode = 1'b0;
				if (send_gap > 0) begin
					send_gap--;
				end else if (conversion_jobs.size() > 0) begin
					case (conversion_jobs[0].kind)
						JOB_POINT: begin
							start_point = 1'b1;
							x_coord <= conversion_jobs[0].x;
							y_coord <= conversion_jobs[0].y;
							z_coord <= conversion_jobs[0].z;
							void'(conversion_jobs.pop_front());
							if (send_burst > 0) begin
								send_burst--;
							end else begin
								if ($urandom_range(0, 99) < 2) send_burst = $urandom_range(30, 100);
								send_gap = idle_length();
							end
						end
						JOB_MODE: begin
							if (settled) begin
								start_mode = 1'b1;
								three_dimensional <= conversion_jobs[0].mode;
								void'(conversion_jobs.pop_front());
							end
						end
						default: begin
							if (settled) void'(conversion_jobs.pop_front());
						end
					endcase
				end
				in_valid <= start_point;
				cfg_valid <= start_mode;
			end
		end
	end

	// Receiver: check each result transaction, then pick the next ready level
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_stall = 0;
			recv_burst = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (awaited_spherical.size() == 0) begin
					$error("result with none expected: radius %0d azimuth %0d polar_angle %0d",
						radius, azimuth, polar_angle);
					mismatch_count++;
				end else begin
					want = awaited_spherical.pop_front();
					if (radius !== want.radius) begin
						$error("radius: expected %0d, actual %0d", want.radius, radius);
						mismatch_count++;
					end
					if (azimuth !== want.azimuth) begin
						$error("azimuth: expected %0d, actual %0d", want.azimuth, azimuth);
						mismatch_count++;
					end
					if (polar_angle !== want.polar) begin
						$error("polar_angle: expected %0d, actual %0d", want.polar, polar_angle);
						mismatch_count++;
					end
				end
				results_checked++;
			end
			if (recv_stall > 0) begin
				recv_stall--;
				out_ready <= 1'b0;
			end else if (!long_hold_done && results_checked >= 300) begin
				// long hold-off: let the pipeline fill and back-pressure the input
				long_hold_done = 1'b1;
				recv_stall = LONG_HOLD - 1;
				out_ready <= 1'b0;
			end else if (recv_burst > 0) begin
				recv_burst--;
				out_ready <= 1'b1;
			end else begin
				if ($urandom_range(0, 99) < 2) recv_burst = $urandom_range(40, 120);
				stall_len = idle_length();
				if (stall_len == 0) begin
					out_ready <= 1'b1;
				end else begin
					recv_stall = stall_len - 1;
					out_ready <= 1'b0;
				end
			end
		end
	end

	// Watchdog: end the run when no transaction moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL cartesian_to_spherical_unit");
				$finish;
			end
		end
	end

	initial begin
		for (int i = 0; i < STAGES; i++) begin
			atan_turn[i] = atan_binary(i);
		end

		// directed points in 3-D mode (reset value)
		add_point('0, '0, '0);
		add_point('0, '0, C_MAX);
		add_point('0, '0, C_MIN);
		add_point('0, '0, 32'd1);
		add_point('0, '0, C_M1);
		add_point(C_MAX, C_MAX, C_MAX);
		add_point(C_MIN, C_MIN, C_MIN);
		add_point(C_MIN, '0, '0);
		add_point('0, C_MIN, '0);
		add_point(C_MAX, '0, '0);
		add_point('0, C_MAX, '0);
		add_point(C_MAX, C_M1, '0);
		add_point(C_M1, '0, C_MIN);
		add_point(32'd1, 32'd1, C_MIN);
		add_point(C_MIN, C_MAX, 32'd1);
		add_point(32'd1, '0, '0);
		add_point(C_M1, C_M1, C_M1);
		add_point(C_MAX, C_MIN, C_MAX);
		// directed points in 2-D mode, z must not matter
		add_control(JOB_MODE, 1'b0);
		add_point('0, '0, C_MAX);
		add_point(C_MAX, C_MAX, C_MIN);
		add_point(C_MIN, C_MIN, 32'd5);
		add_point(C_MIN, C_M1, '0);
		add_point(32'd3, -32'd4, 32'd7);
		add_control(JOB_MODE, 1'b1);

		// random phases, each under its own mode
		for (int p = 0; p < PHASES; p++) begin
			add_control(JOB_MODE, (p < 2) ? p[0] : 1'($urandom_range(0, 1)));
			for (int n = 0; n < PHASE_LEN; n++) begin
				if (p == 3 && n == PHASE_LEN / 2) add_control(JOB_DRAIN, 1'b0);
				add_point(pick_coord(), pick_coord(), pick_coord());
			end
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (conversion_jobs.size() != 0 || in_valid || cfg_valid
				|| awaited_spherical.size() != 0) begin
			@(posedge clk);
		end
		repeat (LATENCY + 8) @(posedge clk);

		if (mismatch_count == 0 && awaited_spherical.size() == 0) begin
			$display("PASS cartesian_to_spherical_unit");
		end else begin
			$display("FAIL cartesian_to_spherical_unit");
		end
		$finish;
	end

endmodule
